// ===== hw/rtl/nps_pkg.sv =====
`default_nettype none

package nps_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_LEN_DEF    = 16;
    localparam int ELEM_WIDTH_DEF = 16;

    // Fixed port widths.
    localparam int LEN_W = 5;
    localparam int POS_W = 4;
    localparam int VAL_W = 16;

    // Length register value after reset.
    localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV_CHK,
        ST_PIV_INIT,
        ST_PIV_RUN,
        ST_SUC_INIT,
        ST_SUC_RUN,
        ST_SWAP,
        ST_REV_RLO,
        ST_REV_RHI,
        ST_REV_WLO,
        ST_REV_WHI,
        ST_EMIT_INIT,
        ST_EMIT_RUN
    } state_t;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_ADV,
        DP_PIV_INIT,
        DP_PIV_RUN,
        DP_SUC_INIT,
        DP_SUC_RUN,
        DP_SWAP,
        DP_REV_RLO,
        DP_REV_RHI,
        DP_REV_WLO,
        DP_REV_WHI,
        DP_EMIT_INIT,
        DP_EMIT_RUN
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic n_zero;
        logic n_short;
        logic piv_hit;
        logic piv_none;
        logic succ_hit;
        logic rev_start;
        logic rev_more;
        logic emit_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/next_permutation_stepper_unit.sv =====
// Load transfers leave busy low; the next item can follow at once.
// An advance over n elements keeps busy high until the controller returns to idle:
// pivot scan, successor scan and suffix reversal all go through the one read port of the store.
// Results leave one per cycle at the end of an advance; the receiver cannot stall them.
// Reset clears the controller and sets the length register to 16; the element store is not cleared.
`default_nettype none

module next_permutation_stepper_unit import nps_pkg::*; #(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             op,
    input  wire logic [POS_W-1:0] position,
    input  wire logic [VAL_W-1:0] element_value,
    input  wire logic             cfg_wr_en,
    input  wire logic [LEN_W-1:0] length_in_use,
    output logic                  result_valid,
    output logic      [POS_W-1:0] out_position,
    output logic      [VAL_W-1:0] out_value,
    output logic                  found,
    output logic                  last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer for load and advance transfers.
    nps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // Element store, scan registers and result fields.
    nps_datapath #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .length_in_use (length_in_use),
        .position      (position),
        .element_value (element_value),
        .out_position  (out_position),
        .out_value     (out_value),
        .found         (found),
        .last          (last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/nps_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module nps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nps_datapath.sv =====
`default_nettype none

module nps_datapath import nps_pkg::*; #(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dp_cmd_t          cmd,
    output dp_stat_t              stat,
    input  wire logic             cfg_wr_en,
    input  wire logic [LEN_W-1:0] length_in_use,
    input  wire logic [POS_W-1:0] position,
    input  wire logic [VAL_W-1:0] element_value,
    output logic      [POS_W-1:0] out_position,
    output logic      [VAL_W-1:0] out_value,
    output logic                  found,
    output logic                  last
);

    localparam int IW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int NW = (CW > LEN_W) ? CW : LEN_W;

    // Control registers.
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [CW-1:0]         n_reg, n_next;
    logic                  found_reg, found_next;

    // Working registers.
    logic [IW-1:0]         cnt_reg, cnt_next;
    logic [IW-1:0]         ridx_reg;
    logic [IW-1:0]         piv_idx_reg, piv_idx_next;
    logic [IW-1:0]         succ_idx_reg, succ_idx_next;
    logic [IW-1:0]         lo_reg, lo_next;
    logic [IW-1:0]         hi_reg, hi_next;
    logic [ELEM_WIDTH-1:0] prev_reg, prev_next;
    logic [ELEM_WIDTH-1:0] piv_val_reg, piv_val_next;
    logic [ELEM_WIDTH-1:0] tmp_reg, tmp_next;

    // Element store port signals.
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [ELEM_WIDTH-1:0] ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_rdata;

    logic [NW-1:0]         len_ext;
    logic [NW-1:0]         n_sat;
    logic                  pos_ok;
    logic                  ridx_top;
    logic                  rd_less;

    nps_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Length in use, saturated to the array size.
    assign len_ext = NW'(len_reg);
    assign n_sat   = (len_ext > NW'(MAX_LEN)) ? NW'(MAX_LEN) : len_ext;
    assign pos_ok  = (32'(position) < 32'(MAX_LEN));

    // The read data belongs to the highest position in use.
    assign ridx_top = ((CW'(ridx_reg) + CW'(1)) == n_reg);
    assign rd_less  = (ram_rdata < prev_reg);

    // Status toward the controller.
    always_comb
    begin
        stat.n_zero    = (n_reg == '0);
        stat.n_short   = (n_reg < CW'(2));
        stat.piv_hit   = !ridx_top && rd_less;
        stat.piv_none  = !ridx_top && !rd_less && (ridx_reg == '0);
        stat.succ_hit  = (ram_rdata > piv_val_reg);
        stat.rev_start = ((CW'(piv_idx_reg) + CW'(2)) < n_reg);
        stat.rev_more  = ((CW'(lo_reg) + CW'(2)) < CW'(hi_reg));
        stat.emit_last = ridx_top;
    end

    // Command decode: store access and next values of the working registers.
    always_comb
    begin
        len_next      = cfg_wr_en ? length_in_use : len_reg;
        n_next        = n_reg;
        found_next    = found_reg;
        cnt_next      = cnt_reg;
        piv_idx_next  = piv_idx_reg;
        succ_idx_next = succ_idx_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        prev_next     = prev_reg;
        piv_val_next  = piv_val_reg;
        tmp_next      = tmp_reg;
        ram_we        = 1'b0;
        ram_waddr     = piv_idx_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = cnt_reg;
        case (cmd)
            DP_NOP:
            begin
            end
            DP_LOAD:
            begin
                ram_we    = pos_ok;
                ram_waddr = IW'(position);
                ram_wdata = ELEM_WIDTH'(element_value);
            end
            DP_ADV:
            begin
                n_next     = CW'(n_sat);
                found_next = 1'b0;
            end
            DP_PIV_INIT, DP_SUC_INIT:
            begin
                ram_raddr = IW'(n_reg - CW'(1));
                cnt_next  = IW'(n_reg - CW'(2));
            end
            DP_PIV_RUN:
            begin
                cnt_next = cnt_reg - IW'(1);
                if (stat.piv_hit)
                begin
                    piv_idx_next = ridx_reg;
                    piv_val_next = ram_rdata;
                    found_next   = 1'b1;
                end
                else
                begin
                    prev_next = ram_rdata;
                end
            end
            DP_SUC_RUN:
            begin
                cnt_next = cnt_reg - IW'(1);
                if (stat.succ_hit)
                begin
                    // The successor value moves into the pivot slot now.
                    ram_we        = 1'b1;
                    ram_waddr     = piv_idx_reg;
                    ram_wdata     = ram_rdata;
                    succ_idx_next = ridx_reg;
                end
            end
            DP_SWAP:
            begin
                ram_we    = 1'b1;
                ram_waddr = succ_idx_reg;
                ram_wdata = piv_val_reg;
                lo_next   = piv_idx_reg + IW'(1);
                hi_next   = IW'(n_reg - CW'(1));
            end
            DP_REV_RLO:
            begin
                ram_raddr = lo_reg;
            end
            DP_REV_RHI:
            begin
                ram_raddr = hi_reg;
                tmp_next  = ram_rdata;
            end
            DP_REV_WLO:
            begin
                ram_we    = 1'b1;
                ram_waddr = lo_reg;
                ram_wdata = ram_rdata;
            end
            DP_REV_WHI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = tmp_reg;
                lo_next   = lo_reg + IW'(1);
                hi_next   = hi_reg - IW'(1);
            end
            DP_EMIT_INIT:
            begin
                ram_raddr = '0;
                cnt_next  = IW'(1);
            end
            DP_EMIT_RUN:
            begin
                cnt_next = cnt_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_RESET;
            n_reg     <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            n_reg     <= n_next;
            found_reg <= found_next;
        end
    end

    // Working registers; the read index follows the read address.
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        ridx_reg     <= ram_raddr;
        piv_idx_reg  <= piv_idx_next;
        succ_idx_reg <= succ_idx_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        prev_reg     <= prev_next;
        piv_val_reg  <= piv_val_next;
        tmp_reg      <= tmp_next;
    end

    // Result fields come straight from the store read register.
    assign out_position = POS_W'(ridx_reg);
    assign out_value    = VAL_W'(ram_rdata);
    assign found        = found_reg;
    assign last         = ridx_top;

endmodule

`default_nettype wire

// ===== hw/rtl/nps_ctrl.sv =====
`default_nettype none

module nps_ctrl import nps_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     op,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy,
    output logic          result_valid
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && op)
                begin
                    state_next = ST_ADV_CHK;
                end
            end
            ST_ADV_CHK:
            begin
                if (stat.n_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.n_short)
                begin
                    state_next = ST_EMIT_INIT;
                end
                else
                begin
                    state_next = ST_PIV_INIT;
                end
            end
            ST_PIV_INIT:
            begin
                state_next = ST_PIV_RUN;
            end
            ST_PIV_RUN:
            begin
                if (stat.piv_hit)
                begin
                    state_next = ST_SUC_INIT;
                end
                else if (stat.piv_none)
                begin
                    state_next = ST_EMIT_INIT;
                end
            end
            ST_SUC_INIT:
            begin
                state_next = ST_SUC_RUN;
            end
            ST_SUC_RUN:
            begin
                if (stat.succ_hit)
                begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                state_next = stat.rev_start ? ST_REV_RLO : ST_EMIT_INIT;
            end
            ST_REV_RLO:
            begin
                state_next = ST_REV_RHI;
            end
            ST_REV_RHI:
            begin
                state_next = ST_REV_WLO;
            end
            ST_REV_WLO:
            begin
                state_next = ST_REV_WHI;
            end
            ST_REV_WHI:
            begin
                state_next = stat.rev_more ? ST_REV_RLO : ST_EMIT_INIT;
            end
            ST_EMIT_INIT:
            begin
                state_next = ST_EMIT_RUN;
            end
            ST_EMIT_RUN:
            begin
                if (stat.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode: datapath command, busy and result strobe.
    always_comb
    begin
        cmd          = DP_NOP;
        busy         = 1'b1;
        result_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd = op ? DP_ADV : DP_LOAD;
                end
            end
            ST_ADV_CHK:   cmd = DP_NOP;
            ST_PIV_INIT:  cmd = DP_PIV_INIT;
            ST_PIV_RUN:   cmd = DP_PIV_RUN;
            ST_SUC_INIT:  cmd = DP_SUC_INIT;
            ST_SUC_RUN:   cmd = DP_SUC_RUN;
            ST_SWAP:      cmd = DP_SWAP;
            ST_REV_RLO:   cmd = DP_REV_RLO;
            ST_REV_RHI:   cmd = DP_REV_RHI;
            ST_REV_WLO:   cmd = DP_REV_WLO;
            ST_REV_WHI:   cmd = DP_REV_WHI;
            ST_EMIT_INIT: cmd = DP_EMIT_INIT;
            ST_EMIT_RUN:
            begin
                cmd          = DP_EMIT_RUN;
                result_valid = 1'b1;
            end
            default:
            begin
                cmd = DP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
    import nps_pkg::*;

    localparam int MAX_ELEMS      = MAX_LEN_DEF;
    // Margin above the longest advance, at n = 16, rounded up.
    localparam int LATENCY_MARGIN = 100;
    localparam int ITEM_TARGET    = 430;
    localparam int QUIET_FROM     = 380;
    localparam int MAX_PRINTS     = 60;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_ADVANCE,
        ROW_LENGTH
    } row_kind_t;

    typedef enum logic [1:0] {
        FOUND_ANY,
        FOUND_NO,
        FOUND_YES
    } found_mark_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
        found_mark_t       mark;
    } stim_row_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        logic             found;
        logic             last;
    } emit_t;

    localparam int NUM_ROWS = 24;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             op;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] element_value;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] length_in_use;
    logic             result_valid;
    logic [POS_W-1:0] out_position;
    logic [VAL_W-1:0] out_value;
    logic             found;
    logic             last;

    // Local copy of the block's state for prediction.
    logic [VAL_W-1:0] perm_store [MAX_ELEMS];
    logic [LEN_W-1:0] len_setting;
    emit_t            expected_emits [$];

    int  fail_count;
    int  items_sent;
    bit  pauses_on;

    stim_row_t directed_rows [NUM_ROWS];

    next_permutation_stepper_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .position      (position),
        .element_value (element_value),
        .cfg_wr_en     (cfg_wr_en),
        .length_in_use (length_in_use),
        .result_valid  (result_valid),
        .out_position  (out_position),
        .out_value     (out_value),
        .found         (found),
        .last          (last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS)
            $display("%0t ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    // Step the local array to its next arrangement and queue the emitted elements.
    // A typed mark overrides the predicted found flag.
    task automatic predict_advance(input found_mark_t mark);
        int               n;
        int               p;
        int               j;
        int               lo;
        int               hi;
        logic             stepped;
        logic [VAL_W-1:0] tmp;
        emit_t            e;
        n = (len_setting > MAX_ELEMS) ? MAX_ELEMS : int'(len_setting);
        stepped = 1'b0;
        if (n >= 2)
        begin
            p = n - 1;
            while (p > 0 && !(perm_store[p-1] < perm_store[p]))
                p--;
            if (p > 0)
            begin
                j = n - 1;
                while (!(perm_store[p-1] < perm_store[j]))
                    j--;
                tmp = perm_store[p-1];
                perm_store[p-1] = perm_store[j];
                perm_store[j] = tmp;
                lo = p;
                hi = n - 1;
                while (lo < hi)
                begin
                    tmp = perm_store[lo];
                    perm_store[lo] = perm_store[hi];
                    perm_store[hi] = tmp;
                    lo++;
                    hi--;
                end
                stepped = 1'b1;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            e.pos   = POS_W'(k);
            e.value = perm_store[k];
            e.found = (mark == FOUND_ANY) ? stepped : (mark == FOUND_YES);
            e.last  = (k == n - 1);
            expected_emits.push_back(e);
        end
    endtask

    // Random sender gaps, switched off late in the run.
    task automatic maybe_pause_sender();
        if (pauses_on && items_sent < QUIET_FROM && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // Drive one item from a falling edge and hold it until the transfer happens.
    task automatic send_item(input logic item_op, input logic [POS_W-1:0] item_pos,
                             input logic [VAL_W-1:0] item_val, input found_mark_t mark);
        maybe_pause_sender();
        start         = 1'b1;
        op            = item_op;
        position      = item_pos;
        element_value = item_val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (item_op == OP_LOAD)
            perm_store[item_pos] = item_val;
        else
            predict_advance(mark);
        items_sent++;
        @(negedge clk);
    endtask

    // Write the length register once the block has drained and gone quiet.
    task automatic set_length(input logic [LEN_W-1:0] new_len);
        start = 1'b0;
        while (expected_emits.size() != 0)
            @(negedge clk);
        repeat (LATENCY_MARGIN) @(negedge clk);
        cfg_wr_en     = 1'b1;
        length_in_use = new_len;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        len_setting = new_len;
    endtask

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        emit_t e;
        if (rst_n && result_valid)
        begin
            if (expected_emits.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected: pos %0d value %0h",
                                          out_position, out_value));
            end
            else
            begin
                e = expected_emits.pop_front();
                if (out_position !== e.pos)
                    report_mismatch($sformatf("out_position %0d, expected %0d",
                                              out_position, e.pos));
                if (out_value !== e.value)
                    report_mismatch($sformatf("out_value %0h at pos %0d, expected %0h",
                                              out_value, e.pos, e.value));
                if (found !== e.found)
                    report_mismatch($sformatf("found %b at pos %0d, expected %b",
                                              found, e.pos, e.found));
                if (last !== e.last)
                    report_mismatch($sformatf("last %b at pos %0d, expected %b",
                                              last, e.pos, e.last));
            end
        end
    end

    // Overall time limit.
    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus.
    initial
    begin
        int                n_used;
        int                n_steps;
        int                fill_style;
        int                pick;
        logic [VAL_W-1:0]  v;
        logic [LEN_W-1:0]  new_len;

        // The first advance runs with the reset length over an ascending array.
        directed_rows = '{
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_YES},
            '{ROW_LOAD,    4'd15, 16'hFFFF,   FOUND_ANY},
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_ANY},
            '{ROW_LENGTH,  4'd0,  16'd1,      FOUND_ANY},
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_NO},
            '{ROW_LENGTH,  4'd0,  16'd0,      FOUND_ANY},
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_NO},
            '{ROW_LENGTH,  4'd0,  16'd2,      FOUND_ANY},
            '{ROW_LOAD,    4'd0,  16'hFFFF,   FOUND_ANY},
            '{ROW_LOAD,    4'd1,  16'd0,      FOUND_ANY},
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_NO},
            '{ROW_LOAD,    4'd0,  16'd0,      FOUND_ANY},
            '{ROW_LOAD,    4'd1,  16'd0,      FOUND_ANY},
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_NO},
            '{ROW_LOAD,    4'd1,  16'hFFFF,   FOUND_ANY},
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_YES},
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_NO},
            '{ROW_LENGTH,  4'd0,  16'd3,      FOUND_ANY},
            '{ROW_LOAD,    4'd0,  16'd1,      FOUND_ANY},
            '{ROW_LOAD,    4'd1,  16'd1,      FOUND_ANY},
            '{ROW_LOAD,    4'd2,  16'd2,      FOUND_ANY},
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_YES},
            '{ROW_LENGTH,  4'd0,  16'd31,     FOUND_ANY},
            '{ROW_ADVANCE, 4'd0,  16'd0,      FOUND_ANY}
        };

        fail_count    = 0;
        items_sent    = 0;
        pauses_on     = 1'b0;
        len_setting   = LEN_RESET;
        rst_n         = 1'b0;
        start         = 1'b0;
        op            = OP_LOAD;
        position      = '0;
        element_value = '0;
        cfg_wr_en     = 1'b0;
        length_in_use = LEN_RESET;
        for (int k = 0; k < MAX_ELEMS; k++)
            perm_store[k] = '0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every store entry is written before any advance reads it.
        for (int k = 0; k < MAX_ELEMS; k++)
            send_item(OP_LOAD, POS_W'(k), VAL_W'(k), FOUND_ANY);

        // Directed table.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            case (directed_rows[r].kind)
                ROW_LOAD:
                    send_item(OP_LOAD, directed_rows[r].pos, directed_rows[r].value,
                              FOUND_ANY);
                ROW_ADVANCE:
                    send_item(OP_ADVANCE, directed_rows[r].pos, directed_rows[r].value,
                              directed_rows[r].mark);
                default:
                    set_length(directed_rows[r].value[LEN_W-1:0]);
            endcase
        end

        // Random phases: set a length, usually refill the array, then mostly advance.
        pauses_on = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                new_len = LEN_W'($urandom_range(0, 1));
            else if (pick <= 6)
                new_len = LEN_W'($urandom_range(2, 5));
            else if (pick == 7)
                new_len = LEN_W'($urandom_range(6, 15));
            else if (pick == 8)
                new_len = LEN_W'(MAX_ELEMS);
            else
                new_len = LEN_W'($urandom_range(17, 31));
            set_length(new_len);
            n_used = (new_len > MAX_ELEMS) ? MAX_ELEMS : int'(new_len);

            // Fill styles: ascending with repeats, descending, small values, full range.
            fill_style = $urandom_range(0, 4);
            if (fill_style != 4)
            begin
                v = VAL_W'($urandom_range(0, 3));
                for (int k = 0; k < n_used; k++)
                begin
                    case (fill_style)
                        0: v = v + VAL_W'($urandom_range(0, 2));
                        1: v = VAL_W'(n_used - k + $urandom_range(0, 1));
                        2: v = VAL_W'($urandom_range(0, 3));
                        default: v = VAL_W'($urandom);
                    endcase
                    send_item(OP_LOAD, POS_W'(k), v, FOUND_ANY);
                end
            end

            n_steps = (n_used > 8) ? $urandom_range(2, 6) : $urandom_range(4, 20);
            for (int s = 0; s < n_steps; s++)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_item(OP_ADVANCE, POS_W'($urandom), VAL_W'($urandom), FOUND_ANY);
                else if ($urandom_range(0, 1) == 0)
                    send_item(OP_LOAD, POS_W'($urandom), VAL_W'($urandom_range(0, 3)),
                              FOUND_ANY);
                else
                    send_item(OP_LOAD, POS_W'($urandom), VAL_W'($urandom), FOUND_ANY);
            end
        end

        // Drain and settle.
        start = 1'b0;
        while (expected_emits.size() != 0)
            @(posedge clk);
        repeat (LATENCY_MARGIN) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/nps_pkg.sv
hw/rtl/nps_ram.sv
hw/rtl/nps_datapath.sv
hw/rtl/nps_ctrl.sv
hw/rtl/next_permutation_stepper_unit.sv
dv/testbench.sv
